// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file blr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hw/rtl/blr_pkg.sv
package blr_pkg;

   localparam int CoordBitsDefault = 10;
   localparam int QueueDepth       = 2;
   localparam int ColorBits        = 24;
   localparam logic [ColorBits-1:0] ColorReset = 24'h00FF00;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    swapped;
      logic    major_neg;
      logic    minor_neg;
   } line_ctl_type;

   localparam int LineCtlBits = $bits(line_ctl_type);

endpackage

// File: hw/rtl/blr_front.sv
module blr_front import blr_pkg::*; #(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                    req_cmd,
   input  logic [COORD_BITS-1:0]   req_x_start,
   input  logic [COORD_BITS-1:0]   req_y_start,
   input  logic [COORD_BITS-1:0]   req_x_end,
   input  logic [COORD_BITS-1:0]   req_y_end,
   output line_ctl_type            ctl,
   output logic [4*COORD_BITS-1:0] data
);

   logic                  x_gt;
   logic                  y_gt;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  swap;

   always_comb begin
      x_gt = req_x_end > req_x_start;
      y_gt = req_y_end > req_y_start;
      adx  = x_gt ? req_x_end - req_x_start : req_x_start - req_x_end;
      ady  = y_gt ? req_y_end - req_y_start : req_y_start - req_y_end;
      swap = adx < ady;
      ctl.cmd     = cmd_type'(req_cmd);
      ctl.swapped = swap;
      if (swap) begin
         ctl.major_neg = !y_gt;
         ctl.minor_neg = !x_gt;
         data = {req_y_start, req_x_start, ady, adx};
      end else begin
         ctl.major_neg = !x_gt;
         ctl.minor_neg = !y_gt;
         data = {req_x_start, req_y_start, adx, ady};
      end
   end

endmodule

// File: hw/rtl/blr_queue.sv
module blr_queue import blr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      full    = count_ff == CntBits'(DEPTH);
      empty   = count_ff == '0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      rdata   = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/blr_back.sv
module blr_back import blr_pkg::*; #(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  line_ctl_type            q_ctl,
   input  logic [4*COORD_BITS-1:0] q_data,
   output logic                    q_pop,
   input  logic                    csr_valid,
   input  logic [ColorBits-1:0]    csr_wdata,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic [ColorBits-1:0]    rsp_color,
   output logic                    rsp_last_pixel
);

   localparam int W       = COORD_BITS;
   localparam int DecBits = COORD_BITS + 3;

   logic [W-1:0] q_major_pos;
   logic [W-1:0] q_minor_pos;
   logic [W-1:0] q_major_delta;
   logic [W-1:0] q_minor_delta;

   logic [W-1:0]       major_pos_ff, major_pos_in;
   logic [W-1:0]       minor_pos_ff, minor_pos_in;
   logic [DecBits-1:0] dec_ff, dec_in;
   logic [DecBits-1:0] inc_pos_ff, inc_pos_in;
   logic [DecBits-1:0] inc_neg_ff, inc_neg_in;
   logic [W-1:0]       remaining_ff, remaining_in;
   logic               major_neg_ff, major_neg_in;
   logic               minor_neg_ff, minor_neg_in;
   logic               swapped_ff, swapped_in;
   logic [ColorBits-1:0] color_ff, color_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]         rsp_x_ff, rsp_x_in;
   logic [W-1:0]         rsp_y_ff, rsp_y_in;
   logic [ColorBits-1:0] rsp_color_ff, rsp_color_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic slot_free;
   logic is_load;
   logic is_step;

   always_comb begin
      {q_major_pos, q_minor_pos, q_major_delta, q_minor_delta} = q_data;
      slot_free = !rsp_valid_ff || rsp_pop;
      q_pop     = !q_empty && slot_free;
      is_load   = q_pop && (q_ctl.cmd == CMD_LOAD);
      is_step   = q_pop && (q_ctl.cmd == CMD_STEP) && (remaining_ff != '0);

      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      dec_in       = dec_ff;
      inc_pos_in   = inc_pos_ff;
      inc_neg_in   = inc_neg_ff;
      remaining_in = remaining_ff;
      major_neg_in = major_neg_ff;
      minor_neg_in = minor_neg_ff;
      swapped_in   = swapped_ff;
      color_in     = csr_valid ? csr_wdata : color_ff;

      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;

      if (is_load) begin
         major_pos_in = q_major_pos;
         minor_pos_in = q_minor_pos;
         inc_pos_in   = DecBits'({q_minor_delta, 1'b0});
         inc_neg_in   = DecBits'({q_minor_delta, 1'b0}) - DecBits'({q_major_delta, 1'b0});
         dec_in       = DecBits'({q_minor_delta, 1'b0}) - DecBits'(q_major_delta);
         remaining_in = q_major_delta;
         major_neg_in = q_ctl.major_neg;
         minor_neg_in = q_ctl.minor_neg;
         swapped_in   = q_ctl.swapped;
      end else if (is_step) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = swapped_ff ? minor_pos_ff : major_pos_ff;
         rsp_y_in     = swapped_ff ? major_pos_ff : minor_pos_ff;
         rsp_color_in = color_ff;
         rsp_last_in  = remaining_ff == W'(1);
         major_pos_in = major_neg_ff ? major_pos_ff - 1'b1 : major_pos_ff + 1'b1;
         if (dec_ff[DecBits-1]) begin
            dec_in = dec_ff + inc_pos_ff;
         end else begin
            minor_pos_in = minor_neg_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
            dec_in       = dec_ff + inc_neg_ff;
         end
         remaining_in = remaining_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= ColorReset;
      end else begin
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
         color_ff     <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      major_pos_ff <= major_pos_in;
      minor_pos_ff <= minor_pos_in;
      dec_ff       <= dec_in;
      inc_pos_ff   <= inc_pos_in;
      inc_neg_ff   <= inc_neg_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      swapped_ff   <= swapped_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_color      = rsp_color_ff;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

// File: hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer.
// Request side is a queue: write an item with req_push while req_full is low.
// req_cmd = 0 loads a line from (x_start, y_start) to (x_end, y_end) and
// replaces any active line; req_cmd = 1 asks for the next pixel of the line.
// Response side is a queue: while rsp_empty is low the oldest pixel is on the
// rsp_ ports; take it with rsp_pop. The end point is not drawn, so a line
// whose longer axis spans M steps gives M pixels; rsp_last_pixel marks the
// final one. Step items on an idle or finished line give no pixel.
// csr_wdata sets the pixel color (reset 0x00FF00); csr_ready is always high.
// A step item goes through the queue entry and then the output register before
// its pixel shows. Throughput: one item per cycle while the output is not stalled;
// the walker does one decision add and one sign test per pixel; a two-entry queue
// decouples the decoder from the walker. When rsp_pop stays low the single output
// register holds, the walker stalls and the queue fills, so req_full goes high.
// Reset (synchronous) empties both queues and stops any active line.
module bresenham_line_rasterizer import blr_pkg::*; #(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_cmd,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [ColorBits-1:0]  rsp_color,
   output logic                  rsp_last_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ColorBits-1:0]  csr_wdata
);

   localparam int DataBits  = 4 * COORD_BITS;
   localparam int EntryBits = LineCtlBits + DataBits;

   line_ctl_type          front_ctl;
   logic [DataBits-1:0]   front_data;
   logic [EntryBits-1:0]  q_rdata;
   logic                  q_empty;
   logic                  q_pop;
   line_ctl_type          q_ctl;
   logic [DataBits-1:0]   q_data;

   blr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .req_cmd     (req_cmd),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .ctl         (front_ctl),
      .data        (front_data)
   );

   blr_queue #(
      .WIDTH(EntryBits),
      .DEPTH(QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata ({front_ctl, front_data}),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign q_ctl  = line_ctl_type'(q_rdata[EntryBits-1:DataBits]);
   assign q_data = q_rdata[DataBits-1:0];

   blr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_ctl          (q_ctl),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .csr_valid      (csr_valid),
      .csr_wdata      (csr_wdata),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_color      (rsp_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   assign csr_ready = 1'b1;

endmodule

// File: hw/rtl/blr_checker.sv
`include "assert_macros.svh"

module blr_checker import blr_pkg::*; #(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic [COORD_BITS-1:0] rsp_pixel_x,
   input logic [COORD_BITS-1:0] rsp_pixel_y,
   input logic [ColorBits-1:0]  rsp_color,
   input logic                  rsp_last_pixel
);

   logic [2*COORD_BITS+ColorBits:0] rsp_fields;

   assign rsp_fields = {rsp_pixel_x, rsp_pixel_y, rsp_color, rsp_last_pixel};

   `ASSERT_CLK_ALWAYS(a_reset_empties_rsp, clock, reset |=> rsp_empty)
   `ASSERT_CLK_ALWAYS(a_reset_frees_req, clock, reset |=> !req_full)
   `ASSERT_CLK(a_full_only_when_stalled, clock, reset, req_full |-> !rsp_empty)
   `ASSERT_CLK(a_rsp_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_fields)))

endmodule

bind bresenham_line_rasterizer blr_checker #(
   .COORD_BITS(COORD_BITS)
) u_blr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_pixel_x    (rsp_pixel_x),
   .rsp_pixel_y    (rsp_pixel_y),
   .rsp_color      (rsp_color),
   .rsp_last_pixel (rsp_last_pixel)
);
